// ===== hw/rtl/jcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// jcbp_pkg
// Shared types and byte codes for the controller command block processor.
// ----------------------------------------------------------------------------
`default_nettype none

package jcbp_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_BUTTONS = 2'd1,
    KIND_RUN     = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  word_index;
    logic [1:0]  channel;
    logic [31:0] data_word;
  } request_t;

  typedef struct packed {
    logic [3:0]  out_index;
    logic [31:0] out_word;
    logic        aborted;
    logic        last;
  } result_t;

  // Scan markers
  localparam logic [7:0] BYTE_PAD = 8'hFF;
  localparam logic [7:0] BYTE_END = 8'hFE;

  // Receive byte flags
  localparam logic [7:0] RX_OVERFLOW = 8'h40;
  localparam logic [7:0] RX_ABSENT   = 8'h80;

  // Commands
  localparam logic [7:0] CMD_STATUS   = 8'h00;
  localparam logic [7:0] CMD_READ     = 8'h01;
  localparam logic [7:0] CMD_ABORT_LO = 8'h02;
  localparam logic [7:0] CMD_ABORT_HI = 8'h05;

  // Status reply bytes, first byte in the low lane
  localparam logic [7:0] STATUS_B0 = 8'h05;
  localparam logic [7:0] STATUS_B1 = 8'h00;
  localparam logic [7:0] STATUS_B2 = 8'h02;

  localparam logic [7:0] RX_MAX_STATUS = 8'h03;
  localparam logic [5:0] CHAN_MAX      = 6'd63;

endpackage

`default_nettype wire

// ===== hw/rtl/jcbp_ram.sv =====
// ----------------------------------------------------------------------------
// jcbp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module jcbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/joybus_command_block_processor_unit.sv =====
// ----------------------------------------------------------------------------
// joybus_command_block_processor_unit
// Controller command block processor: command RAM, button store, scan engine.
// ----------------------------------------------------------------------------
// Loads (kind 0) and button updates (kind 1) leave busy low and may arrive
// back to back. A run (kind 2) holds busy while the scan walks the command
// RAM through its single word-wide memory port: each byte is read, then
// decoded; a channel entry also reads its receive and command bytes, and
// every reply byte written back is read, then merged and written. The
// processed RAM then streams out one word a cycle, min(RAM_BYTES/4, 16) words
// with strobe high for one cycle each; the receiver cannot stall, so take
// every item on the cycle it shows.
// The command RAM has no reset: load every word before the first run.
// ----------------------------------------------------------------------------
`default_nettype none

module joybus_command_block_processor_unit
  import jcbp_pkg::*;
#(
  parameter int RAM_BYTES = 64,
  parameter int CHANNELS  = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire request_t request,
  output logic          busy,
  output logic          strobe,
  output result_t       result,
  input  wire logic     cfg_we,
  input  wire logic [3:0] cfg_data
);

  localparam int WORDS     = RAM_BYTES / 4;
  localparam int OUT_WORDS = (WORDS < 16) ? WORDS : 16;
  localparam int WAW       = $clog2(WORDS);
  localparam int OIW       = $clog2(OUT_WORDS);
  localparam int CW        = $clog2(RAM_BYTES + 256);
  localparam int CHW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [CW-1:0]  RAM_END  = CW'(RAM_BYTES);
  localparam logic [OIW-1:0] OUT_LAST = OIW'(OUT_WORDS - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FETCH = 8'b0000_0010,
    S_TX    = 8'b0000_0100,
    S_RX    = 8'b0000_1000,
    S_CMD   = 8'b0001_0000,
    S_WRD   = 8'b0010_0000,
    S_WWR   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  function automatic logic [7:0] get_byte(input logic [31:0] w, input logic [1:0] off);
    logic [7:0] b;
    unique case (off)
      2'd0: b = w[31:24];
      2'd1: b = w[23:16];
      2'd2: b = w[15:8];
      2'd3: b = w[7:0];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] off,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = w;
    unique case (off)
      2'd0: r[31:24] = b;
      2'd1: r[23:16] = b;
      2'd2: r[15:8]  = b;
      2'd3: r[7:0]   = b;
      default: r[7:0] = b;
    endcase
    return r;
  endfunction

  // Control and scan registers
  state_t         state, state_next;
  logic [CW-1:0]  cursor, cursor_next;
  logic [5:0]     chan, chan_next;
  logic [7:0]     tx, tx_next;
  logic [7:0]     rx, rx_next;
  logic [CW-1:0]  wr_addr, wr_addr_next;
  logic [31:0]    pay, pay_next;
  logic [2:0]     wr_cnt, wr_cnt_next;
  logic           aborted, aborted_next;
  logic [OIW-1:0] oi, oi_next;
  logic           rd_v, rd_v_next;
  logic [OIW-1:0] rd_idx, rd_idx_next;
  logic           rd_last, rd_last_next;
  logic [3:0]     present_mask;
  logic [31:0]    buttons [CHANNELS];

  // Memory port
  logic           we;
  logic [WAW-1:0] waddr, raddr;
  logic [31:0]    wdata, rdata;

  logic           accept;
  logic [CW-1:0]  cursor_p1;
  logic [7:0]     cur_byte, cmd_byte;
  logic [5:0]     chan_inc;
  logic           pres;
  logic [31:0]    btn;

  assign busy      = (state != S_IDLE) || rd_v;
  assign accept    = start && !busy;
  assign cursor_p1 = cursor + CW'(1);
  assign cur_byte  = get_byte(rdata, cursor[1:0]);
  assign cmd_byte  = get_byte(rdata, cursor_p1[1:0]);
  assign chan_inc  = (chan == CHAN_MAX) ? chan : chan + 6'd1;
  assign pres      = (chan < 6'(CHANNELS)) && (chan < 6'd4) && present_mask[chan[1:0]];
  assign btn       = buttons[CHW'(chan)];

  jcbp_ram #(
    .WIDTH (32),
    .DEPTH (WORDS),
    .AW    (WAW)
  ) u_cmd_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next   = state;
    cursor_next  = cursor;
    chan_next    = chan;
    tx_next      = tx;
    rx_next      = rx;
    wr_addr_next = wr_addr;
    pay_next     = pay;
    wr_cnt_next  = wr_cnt;
    aborted_next = aborted;
    oi_next      = oi;
    rd_v_next    = 1'b0;
    rd_idx_next  = rd_idx;
    rd_last_next = rd_last;
    we           = 1'b0;
    waddr        = WAW'(request.word_index);
    wdata        = request.data_word;
    raddr        = WAW'(cursor >> 2);

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (request.kind)
            KIND_LOAD: begin
              we = 7'(request.word_index) < 7'(WORDS);
            end
            KIND_RUN: begin
              cursor_next = '0;
              chan_next   = '0;
              state_next  = S_FETCH;
            end
            default: begin
            end
          endcase
        end
      end

      S_FETCH: begin
        // Issue the read of the byte under the cursor, or close the scan.
        if (cursor >= RAM_END) begin
          aborted_next = 1'b0;
          oi_next      = '0;
          state_next   = S_EMIT;
        end else begin
          state_next = S_TX;
        end
      end

      S_TX: begin
        raddr = WAW'(cursor_p1 >> 2);
        priority if (cur_byte == BYTE_PAD) begin
          cursor_next = cursor_p1;
          state_next  = S_FETCH;
        end else if (cur_byte == BYTE_END) begin
          aborted_next = 1'b0;
          oi_next      = '0;
          state_next   = S_EMIT;
        end else begin
          cursor_next = cursor_p1;
          tx_next     = cur_byte;
          if (cur_byte == 8'd0) begin
            chan_next  = chan_inc;
            state_next = S_FETCH;
          end else if (cursor + CW'(2) >= RAM_END) begin
            aborted_next = 1'b0;
            oi_next      = '0;
            state_next   = S_EMIT;
          end else begin
            state_next = S_RX;
          end
        end
      end

      S_RX: begin
        rx_next    = cur_byte;
        raddr      = WAW'(cursor_p1 >> 2);
        state_next = S_CMD;
      end

      S_CMD: begin
        priority if (cmd_byte == CMD_STATUS) begin
          cursor_next = cursor + CW'(5);
          state_next  = S_WRD;
          priority if (!pres) begin
            wr_addr_next = cursor;
            pay_next     = {24'd0, rx | RX_ABSENT};
            wr_cnt_next  = 3'd1;
          end else if (rx > RX_MAX_STATUS) begin
            wr_addr_next = cursor;
            pay_next     = {24'd0, rx | RX_OVERFLOW};
            wr_cnt_next  = 3'd1;
          end else begin
            wr_addr_next = cursor + CW'(2);
            pay_next     = {8'd0, STATUS_B2, STATUS_B1, STATUS_B0};
            wr_cnt_next  = 3'd3;
          end
        end else if (cmd_byte == CMD_READ) begin
          cursor_next = cursor + CW'(6);
          state_next  = S_WRD;
          if (pres) begin
            wr_addr_next = cursor + CW'(2);
            pay_next     = btn;
            wr_cnt_next  = 3'd4;
          end else begin
            wr_addr_next = cursor;
            pay_next     = {24'd0, rx | RX_ABSENT};
            wr_cnt_next  = 3'd1;
          end
        end else if (cmd_byte >= CMD_ABORT_LO && cmd_byte <= CMD_ABORT_HI) begin
          aborted_next = 1'b1;
          oi_next      = '0;
          state_next   = S_EMIT;
        end else begin
          // Unknown command: skip its bytes and leave the RAM alone.
          cursor_next = cursor_p1 + CW'(tx[5:0]) + CW'(rx[5:0]);
          chan_next   = chan_inc;
          state_next  = S_FETCH;
        end
      end

      S_WRD: begin
        raddr = WAW'(wr_addr >> 2);
        // Reply bytes run upward, so once one falls off the end all do.
        if (wr_addr >= RAM_END) begin
          chan_next  = chan_inc;
          state_next = S_FETCH;
        end else begin
          state_next = S_WWR;
        end
      end

      S_WWR: begin
        we           = 1'b1;
        waddr        = WAW'(wr_addr >> 2);
        wdata        = put_byte(rdata, wr_addr[1:0], pay[7:0]);
        wr_addr_next = wr_addr + CW'(1);
        pay_next     = pay >> 8;
        wr_cnt_next  = wr_cnt - 3'd1;
        if (wr_cnt == 3'd1) begin
          chan_next  = chan_inc;
          state_next = S_FETCH;
        end else begin
          state_next = S_WRD;
        end
      end

      S_EMIT: begin
        raddr        = WAW'(oi);
        rd_v_next    = 1'b1;
        rd_idx_next  = oi;
        rd_last_next = (oi == OUT_LAST);
        oi_next      = oi + OIW'(1);
        if (oi == OUT_LAST) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cursor  <= '0;
      chan    <= '0;
      wr_cnt  <= '0;
      aborted <= 1'b0;
      oi      <= '0;
      rd_v    <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      state   <= state_next;
      cursor  <= cursor_next;
      chan    <= chan_next;
      wr_cnt  <= wr_cnt_next;
      aborted <= aborted_next;
      oi      <= oi_next;
      rd_v    <= rd_v_next;
      strobe  <= rd_v;
    end
  end

  // Scan payload and output item
  always_ff @(posedge clk) begin
    tx      <= tx_next;
    rx      <= rx_next;
    wr_addr <= wr_addr_next;
    pay     <= pay_next;
    rd_idx  <= rd_idx_next;
    rd_last <= rd_last_next;
    result.out_index <= 4'(rd_idx);
    result.out_word  <= rdata;
    result.aborted   <= aborted;
    result.last      <= rd_last;
  end

  // Attached-controller mask
  always_ff @(posedge clk) begin
    if (rst) begin
      present_mask <= 4'd1;
    end else if (cfg_we) begin
      present_mask <= cfg_data;
    end
  end

  // Button store: cleared at reset, one word per channel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        buttons[i] <= '0;
      end
    end else if (accept && request.kind == KIND_BUTTONS
                 && 4'(request.channel) < 4'(CHANNELS)) begin
      buttons[CHW'(request.channel)] <= request.data_word;
    end
  end

`ifndef SYNTHESIS
  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !strobe)
    else $error("item stream continued past the last word");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe && result.out_index == $past(result.out_index) + 4'd1)
    else $error("output word index did not advance by one");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_WWR |-> wr_addr < RAM_END)
    else $error("reply byte written past the end of the command RAM");

  a_run_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept && request.kind == KIND_RUN |=> state == S_FETCH && cursor == '0)
    else $error("run item did not start the scan at byte zero");
`endif

endmodule

`default_nettype wire

// ===== dv/joybus_command_block_processor_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joybus_command_block_processor_unit_test
// Self-checking bench for the controller command block processor. Command
// blocks are loaded word by word, button words are set per channel, and runs
// are issued under several attach masks. A behavioral scan of the command
// RAM predicts every streamed word, which is checked field by field.
// ----------------------------------------------------------------------------

module joybus_command_block_processor_unit_test;
  import jcbp_pkg::*;

  localparam int RAM_BYTES   = 64;
  localparam int CHANNELS    = 4;
  localparam int WORDS       = RAM_BYTES / 4;
  localparam int QUIET_LIMIT = 5000;
  localparam int LOAD_SETTLE = 8;
  localparam int END_SETTLE  = 64;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        start    = 1'b0;
  request_t    request  = '0;
  logic        cfg_we   = 1'b0;
  logic [3:0]  cfg_data = 4'd0;
  logic        busy;
  logic        strobe;
  result_t     result;

  // Predictor state: command RAM image, button words, attach mask
  logic [7:0]  ram_image    [RAM_BYTES];
  logic [31:0] button_words [CHANNELS];
  logic [3:0]  attached_mask = 4'd1;

  request_t    pending_items  [$];
  result_t     expected_words [$];
  result_t     due_word;

  // Scratch image for building one command block before it is queued
  logic [7:0]  block_img    [RAM_BYTES];
  logic [31:0] opening_block [WORDS];

  int gap_pct      = 28;
  int n_errors     = 0;
  int items_queued = 0;
  int quiet_cycles = 0;

  joybus_command_block_processor_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .request  (request),
    .busy     (busy),
    .strobe   (strobe),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Drop writes that fall past the end of the RAM
  function automatic void ram_poke(int a, logic [7:0] v);
    if (a < RAM_BYTES) ram_image[a] = v;
  endfunction

  // Walk the command RAM in place; return 1 when an abort-range command stops it
  function automatic bit scan_ram();
    int         cur;
    int         chan;
    int         k;
    logic [7:0] tx;
    logic [7:0] rx;
    logic [7:0] cmd;
    bit         pres;
    cur  = 0;
    chan = 0;
    while (1'b1) begin
      // skip padding
      while (cur < RAM_BYTES) begin
        if (ram_image[cur] != BYTE_PAD) break;
        cur++;
      end
      if (cur >= RAM_BYTES) return 1'b0;
      if (ram_image[cur] == BYTE_END) return 1'b0;
      tx = ram_image[cur];
      cur++;
      if (tx != 8'h00) begin
        // receive and command bytes must both lie inside the RAM
        if (cur + 1 >= RAM_BYTES) return 1'b0;
        rx   = ram_image[cur];
        cmd  = ram_image[cur + 1];
        pres = 1'b0;
        if (chan < CHANNELS && chan < 4) pres = attached_mask[chan];
        if (cmd == CMD_STATUS) begin
          if (!pres) begin
            ram_poke(cur, rx | RX_ABSENT);
          end else if (rx > RX_MAX_STATUS) begin
            ram_poke(cur, rx | RX_OVERFLOW);
          end else begin
            ram_poke(cur + 2, STATUS_B0);
            ram_poke(cur + 3, STATUS_B1);
            ram_poke(cur + 4, STATUS_B2);
          end
          cur += 5;
        end else if (cmd == CMD_READ) begin
          if (pres) begin
            // low byte of the button word goes first
            for (k = 0; k < 4; k++) ram_poke(cur + 2 + k, button_words[chan][8*k +: 8]);
          end else begin
            ram_poke(cur, rx | RX_ABSENT);
          end
          cur += 6;
        end else if (cmd >= CMD_ABORT_LO && cmd <= CMD_ABORT_HI) begin
          return 1'b1;
        end else begin
          // unknown command: step over its bytes, change nothing
          cur += 1 + int'(tx & 8'h3F) + int'(rx & 8'h3F);
        end
      end
      if (chan < int'(CHAN_MAX)) chan++;
    end
    return 1'b0;
  endfunction

  // Apply one accepted item to the predictor and queue the words it yields
  function automatic void predict_item(request_t it);
    int      i;
    bit      stopped;
    result_t word;
    case (it.kind)
      KIND_LOAD: begin
        for (i = 0; i < 4; i++) ram_image[4*it.word_index + i] = it.data_word[31 - 8*i -: 8];
      end
      KIND_BUTTONS: begin
        button_words[it.channel] = it.data_word;
      end
      KIND_RUN: begin
        stopped = scan_ram();
        for (i = 0; i < WORDS; i++) begin
          word.out_index = i[3:0];
          word.out_word  = {ram_image[4*i], ram_image[4*i + 1],
                            ram_image[4*i + 2], ram_image[4*i + 3]};
          word.aborted   = stopped;
          word.last      = (i == WORDS - 1);
          expected_words.push_back(word);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present the oldest pending item, hold it until busy is low
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_item(request);
        pending_items.delete(0);
      end
      // hold the item while the block is busy, otherwise pick the next one
      if (!(start && busy)) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
          start   <= 1'b1;
          request <= pending_items[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every strobed word is taken on the cycle it shows
  // --------------------------------------------------------------------------
  function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, label, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_words.size() == 0) begin
        $display("%0t ns: unexpected word, expected none, got %h", $time, result);
        n_errors++;
      end else begin
        due_word = expected_words.pop_front();
        check_field("out_index", 32'(due_word.out_index), 32'(result.out_index));
        check_field("out_word",  due_word.out_word,       result.out_word);
        check_field("aborted",   32'(due_word.aborted),   32'(result.aborted));
        check_field("last",      32'(due_word.last),      32'(result.last));
      end
    end
  end

  // Watchdog: count cycles in which no item and no word moves
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_item(kind_t k, logic [3:0] wi, logic [1:0] ch, logic [31:0] d);
    request_t it;
    it.kind       = k;
    it.word_index = wi;
    it.channel    = ch;
    it.data_word  = d;
    pending_items.push_back(it);
    if (k != KIND_NONE) items_queued++;
  endtask

  // Wait until everything queued has gone in and come out, then let it settle
  task automatic drain(int settle);
    do @(negedge clk);
    while (pending_items.size() != 0 || start || busy || expected_words.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Write the attach mask; only called while the block is idle
  task automatic write_mask(logic [3:0] m);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    attached_mask = m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void block_put(int p, logic [7:0] v);
    if (p < RAM_BYTES) block_img[p] = v;
  endfunction

  // Write one channel entry at p into the scratch image, return the next slot
  function automatic int put_entry(int p);
    int         r;
    int         k;
    logic [7:0] tx;
    logic [7:0] rx;
    if ($urandom_range(3) == 0) begin
      k = $urandom_range(1, 3);
      repeat (k) begin
        block_put(p, BYTE_PAD);
        p++;
      end
    end
    tx = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 8'hFD)) : 8'd1;
    rx = ($urandom_range(1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    r  = $urandom_range(99);
    if (r < 30) begin
      block_put(p, tx); block_put(p + 1, rx); block_put(p + 2, CMD_STATUS);
      return p + 6;
    end else if (r < 60) begin
      block_put(p, tx); block_put(p + 1, rx); block_put(p + 2, CMD_READ);
      return p + 7;
    end else if (r < 72) begin
      block_put(p, 8'h00);
      return p + 1;
    end else if (r < 85) begin
      // unknown command with short counts so the scan lands on the next entry
      tx = 8'($urandom_range(1, 5));
      rx = 8'($urandom_range(0, 5));
      block_put(p, tx); block_put(p + 1, rx);
      block_put(p + 2, 8'($urandom_range(6, 255)));
      return p + 2 + int'(tx) + int'(rx);
    end else if (r < 92) begin
      block_put(p, tx); block_put(p + 1, rx);
      block_put(p + 2, 8'($urandom_range(CMD_ABORT_LO, CMD_ABORT_HI)));
      return p + 3;
    end
    block_put(p, BYTE_END);
    return p + 1;
  endfunction

  // Build a random but mostly well-formed command block, load it, then run
  task automatic queue_scan_block();
    int p;
    int k;
    int n;
    int r;
    int nw;
    for (k = 0; k < RAM_BYTES; k++) block_img[k] = 8'($urandom);
    p = 0;
    r = $urandom_range(9);
    if (r == 0) begin
      // pad up to the tail so the entry runs into the end of the RAM
      n = $urandom_range(52, 63);
      for (k = 0; k < n; k++) block_img[k] = BYTE_PAD;
      p = n;
    end else if (r == 1) begin
      // long stretch of zero counts pushes the channel number up toward its ceiling
      n = $urandom_range(40, 63);
      for (k = 0; k < n; k++) block_img[k] = 8'h00;
      p = n;
    end
    n = $urandom_range(1, 8);
    repeat (n) p = put_entry(p);
    if ($urandom_range(4) != 0) begin
      block_put(p, BYTE_END);
      p++;
    end
    // load only the words the entries touch, except for the long layouts
    nw = (r <= 1 || p >= RAM_BYTES) ? WORDS : (p + 3) / 4;
    for (k = 0; k < nw; k++)
      queue_item(KIND_LOAD, k[3:0], 2'($urandom),
                 {block_img[4*k], block_img[4*k + 1], block_img[4*k + 2], block_img[4*k + 3]});
    if ($urandom_range(1) == 0) begin
      n = $urandom_range(1, 2);
      repeat (n) queue_item(KIND_BUTTONS, 4'($urandom), 2'($urandom), $urandom);
    end
    queue_item(KIND_RUN, 4'($urandom), 2'($urandom), $urandom);
  endtask

  task automatic random_traffic(int n_items);
    int stop_at;
    int k;
    stop_at = items_queued + n_items;
    while (items_queued < stop_at) begin
      if ($urandom_range(99) < 15) begin
        // noise: stray loads, button updates, runs and unused kinds
        k = $urandom_range(1, 4);
        repeat (k) queue_item(kind_t'($urandom_range(0, 3)), 4'($urandom), 2'($urandom),
                              $urandom);
      end else begin
        queue_scan_block();
      end
    end
  endtask

  initial begin
    int k;
    for (k = 0; k < RAM_BYTES; k++) ram_image[k] = 8'h00;
    for (k = 0; k < CHANNELS; k++) button_words[k] = 32'd0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Channels 0 and 2 attached for the opening block
    write_mask(4'b0101);
    gap_pct = 28;

    // Opening block, one entry per channel:
    //   pad, ch0 status (reply written), ch1 read while absent,
    //   ch2 read (button bytes low first), ch3 skipped by a zero count,
    //   two pads, ch4 status (channel past the last one), ch5 unknown
    //   command stepped over, then the end marker. Trailing words carry
    //   data extremes.
    opening_block = '{32'hFF010300, 32'hAABBCC01, 32'h04011122, 32'h33440104,
                      32'h01556677, 32'h8800FFFF, 32'h01010099, 32'h99990302,
                      32'h07123456, 32'h78FE0000, 32'h00000000, 32'hFFFFFFFF,
                      32'h80000000, 32'h7FFFFFFF, 32'h01234567, 32'hFEDCBA98};
    for (k = 0; k < WORDS; k++) queue_item(KIND_LOAD, k[3:0], 2'($urandom), opening_block[k]);
    queue_item(KIND_BUTTONS, 4'hF, 2'd2, 32'hA1B2C3D4);
    queue_item(KIND_BUTTONS, 4'h0, 2'd1, 32'hFFFFFFFF);
    queue_item(KIND_NONE, 4'($urandom), 2'($urandom), $urandom);
    queue_item(KIND_RUN, 4'h0, 2'd3, 32'h00000000);

    // ch0 status with an oversized receive count, then ch1 aborts the scan
    queue_item(KIND_LOAD, 4'd0, 2'd0, 32'h01070000);
    queue_item(KIND_LOAD, 4'd1, 2'd3, 32'h5A5A0101);
    queue_item(KIND_LOAD, 4'd2, 2'd1, 32'h03000000);
    queue_item(KIND_RUN, 4'hF, 2'd0, 32'hFFFFFFFF);
    drain(LOAD_SETTLE);

    // Everything attached, sender idles now and then
    write_mask(4'hF);
    random_traffic(30);
    drain(LOAD_SETTLE);

    // Nothing attached, sender idles often
    gap_pct = 45;
    write_mask(4'h0);
    random_traffic(30);
    drain(LOAD_SETTLE);

    // Mixed mask, back-to-back items
    gap_pct = 0;
    write_mask(4'($urandom_range(1, 14)));
    random_traffic(30);
    drain(END_SETTLE);

    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/jcbp_pkg.sv
hw/rtl/jcbp_ram.sv
hw/rtl/joybus_command_block_processor_unit.sv
dv/joybus_command_block_processor_unit_test.sv
